/* sv/zcmp_pkg.sv */
// ----------------------------------------------------------------------------
// zcmp_pkg
// Shared constants and types for the zig-zag count matrix power block.
// ----------------------------------------------------------------------------
package zcmp_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 64;
  localparam logic [29:0] MODULUS = 30'd1000000007;
  localparam int unsigned LEN_W = 30;
  localparam int unsigned RW_W  = 7;
  localparam int unsigned VAL_W = 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CHECK,
    ST_MUL,
    ST_COPY,
    ST_SUM,
    ST_OUT
  } state_t;

  // a + b mod P, both below P
  function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] s;
    logic [30:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, MODULUS};
    add_mod = d[30] ? s[29:0] : d[29:0];
  endfunction

endpackage

/* sv/zcmp_modmul.sv */
// ----------------------------------------------------------------------------
// zcmp_modmul
// Sequential shift-add modular multiplier, one bit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module zcmp_modmul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [29:0] a,
  input  logic [29:0] b,
  output logic        done,
  output logic [29:0] prod
);
  import zcmp_pkg::*;

  logic [29:0] acc;
  logic [29:0] mcand;
  logic [29:0] mplier;
  logic [4:0]  bit_cnt;
  logic        busy;
  logic [29:0] acc_dbl;

  assign acc_dbl = add_mod(acc, acc);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        acc     <= '0;
        mcand   <= a;
        mplier  <= b;
        bit_cnt <= 5'd29;
      end else if (busy) begin
        // MSB first: acc = 2*acc + bit*a
        acc    <= mplier[29] ? add_mod(acc_dbl, mcand) : acc_dbl;
        mplier <= {mplier[28:0], 1'b0};
        if (bit_cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        bit_cnt <= bit_cnt - 5'd1;
      end
    end
  end

endmodule

/* sv/zigzag_count_matrix_power.sv */
// ----------------------------------------------------------------------------
// zigzag_count_matrix_power
// Counts zig-zag arrays as 2 * sum(T^(n-1)) mod 1e9+7 by square-and-multiply.
// ----------------------------------------------------------------------------
// One request at a time. An item first loads its result and base matrices. Then,
// for each exponent bit, it runs one or two m x m matrix products. Each product
// uses one shared bit-serial modular multiply-accumulate, with an address
// phase, a data phase and a multiply wait per term. The result, base and
// product matrices sit in synchronous memories with registered reads; result
// and base are each read at two addresses. Each product is followed by a copy
// into result or base. Last, the result matrix is summed. A 64-wide item with
// a 30-bit length runs up to about 60 products. No clearing pass after reset.
module zigzag_count_matrix_power #(
  parameter int unsigned MAX_WIDTH = zcmp_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // array_length[29:0], range_width[36:30], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // count[29:0], zero
);
  import zcmp_pkg::*;

  localparam int unsigned IW = $clog2(MAX_WIDTH);
  localparam int unsigned AW = 2 * IW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned MW = $clog2(MAX_WIDTH + 1);

  state_t state, state_next;

  logic [VAL_W-1:0] res_mem  [DEPTH];
  logic [VAL_W-1:0] base_mem [DEPTH];
  logic [VAL_W-1:0] prod_mem [DEPTH];

  logic [LEN_W-1:0] exponent_left;
  logic [VAL_W-1:0] running_sum;
  logic [MW-1:0]    m;
  logic [IW-1:0]    ii, jj, kk;
  logic             sq_pass;     // 0: result*base, 1: base*base
  logic [1:0]       phase;       // within a mul term: 0 addr, 1 data, 2 wait mul
  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] rd_a, rd_b, rd_r, rd_p;
  logic             mul_start, mul_done;
  logic [VAL_W-1:0] mul_prod;
  logic [VAL_W-1:0] count_q;
  logic             i_last, j_last, k_last;

  assign i_last = (MW'(ii) == MW'(m - 1'b1));
  assign j_last = (MW'(jj) == MW'(m - 1'b1));
  assign k_last = (MW'(kk) == MW'(m - 1'b1));

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {2'b0, count_q};

  // memory read ports, registered
  always_ff @(posedge clk) begin
    rd_a <= sq_pass ? base_mem[{ii, kk}] : res_mem[{ii, kk}];
    rd_b <= base_mem[{kk, jj}];
    rd_r <= res_mem[{ii, jj}];
    rd_p <= prod_mem[{ii, jj}];
  end

  assign mul_start = (state == ST_MUL) && (phase == 2'd1);

  zcmp_modmul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (rd_a),
    .b     (rd_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = (s_tdata[36:30] == '0) ? ST_SUM : ST_INIT;
      ST_INIT:  if (i_last && j_last) state_next = ST_CHECK;
      ST_CHECK: state_next = (exponent_left == '0) ? ST_SUM : ST_MUL;
      ST_MUL:   if (mul_done && k_last && i_last && j_last) state_next = ST_COPY;
      ST_COPY:  if (phase == 2'd1 && i_last && j_last) state_next = sq_pass ? ST_CHECK : ST_MUL;
      ST_SUM:   if (m == '0 || (phase == 2'd1 && i_last && j_last)) state_next = ST_OUT;
      ST_OUT:   if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      exponent_left <= '0;
      running_sum <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (s_tvalid) begin
          m <= ({1'b0, s_tdata[36:30]} > 8'(MAX_WIDTH)) ? MW'(MAX_WIDTH)
                                                        : MW'(s_tdata[36:30]);
          exponent_left <= (s_tdata[29:0] == '0) ? '0 : s_tdata[29:0] - 1'b1;
          ii <= '0; jj <= '0; kk <= '0; phase <= '0;
          running_sum <= '0;
        end
        ST_INIT: begin
          res_mem[{ii, jj}]  <= (ii == jj) ? VAL_W'(1) : '0;
          base_mem[{ii, jj}] <= ((MW+1)'(ii) + (MW+1)'(jj) >= (MW+1)'(m)) ? VAL_W'(1) : '0;
          jj <= j_last ? '0 : jj + 1'b1;
          if (j_last) ii <= i_last ? '0 : ii + 1'b1;
        end
        ST_CHECK: begin
          sq_pass <= ~exponent_left[0];
          ii <= '0; jj <= '0; kk <= '0; phase <= '0; acc <= '0;
        end
        ST_MUL: begin
          if (phase != 2'd2) phase <= phase + 2'd1;
          if (mul_done) begin
            phase <= '0;
            if (k_last) begin
              prod_mem[{ii, jj}] <= add_mod(acc, mul_prod);
              acc <= '0;
              kk <= '0;
              jj <= j_last ? '0 : jj + 1'b1;
              if (j_last) ii <= i_last ? '0 : ii + 1'b1;
            end else begin
              acc <= add_mod(acc, mul_prod);
              kk <= kk + 1'b1;
            end
          end
        end
        ST_COPY: begin
          if (phase == 2'd0) phase <= 2'd1;
          else begin
            phase <= '0;
            if (sq_pass) base_mem[{ii, jj}] <= rd_p;
            else res_mem[{ii, jj}] <= rd_p;
            jj <= j_last ? '0 : jj + 1'b1;
            if (j_last) ii <= i_last ? '0 : ii + 1'b1;
            if (i_last && j_last) begin
              if (sq_pass) exponent_left <= exponent_left >> 1;
              sq_pass <= 1'b1;
            end
          end
        end
        ST_SUM: begin
          if (phase == 2'd0) phase <= 2'd1;
          else begin
            phase <= '0;
            running_sum <= add_mod(running_sum, rd_r);
            jj <= j_last ? '0 : jj + 1'b1;
            if (j_last) ii <= i_last ? '0 : ii + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM && state_next == ST_OUT) begin
      if (m == '0) count_q <= '0;
      else count_q <= add_mod(add_mod(running_sum, rd_r), add_mod(running_sum, rd_r));
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("output changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready) else $error("ready while busy");
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> count_q < MODULUS) else $error("count out of range");

endmodule

/* tb/sv/zcmp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zcmp_checker
// Watches both stream channels of the zig-zag count block. Every accepted
// request is turned into its expected count by a local matrix-power model;
// every accepted result is matched against the oldest expected count.
// ----------------------------------------------------------------------------
module zcmp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  import zcmp_pkg::*;

  localparam int unsigned MW = DEF_MAX_WIDTH;
  localparam longint unsigned P = 64'd1000000007;

  logic [29:0] count_queue[$];
  longint unsigned pow_m[MW][MW];
  longint unsigned sq_m[MW][MW];
  longint unsigned tmp_m[MW][MW];

  // tmp = a * b over the leading w x w corner, mod P
  task automatic mat_mul_mod(input bit a_is_pow, input int w);
    longint unsigned acc;
    longint unsigned av;
    for (int i = 0; i < w; i++) begin
      for (int j = 0; j < w; j++) begin
        acc = 0;
        for (int k = 0; k < w; k++) begin
          av = a_is_pow ? pow_m[i][k] : sq_m[i][k];
          acc = (acc + (av * sq_m[k][j]) % P) % P;
        end
        tmp_m[i][j] = acc;
      end
    end
  endtask

  task automatic zigzag_count(input logic [29:0] len, input logic [6:0] rw,
                              output logic [29:0] cnt);
    int w;
    logic [29:0] e;
    longint unsigned total;
    w = (rw > MW) ? MW : rw;
    for (int i = 0; i < w; i++)
      for (int j = 0; j < w; j++) begin
        pow_m[i][j] = (i == j) ? 1 : 0;
        sq_m[i][j] = (i + j >= w) ? 1 : 0;
      end
    e = (len == 0) ? 30'd0 : len - 30'd1;
    while (e != 0) begin
      if (e[0]) begin
        mat_mul_mod(1'b1, w);
        for (int i = 0; i < w; i++)
          for (int j = 0; j < w; j++) pow_m[i][j] = tmp_m[i][j];
      end
      mat_mul_mod(1'b0, w);
      for (int i = 0; i < w; i++)
        for (int j = 0; j < w; j++) sq_m[i][j] = tmp_m[i][j];
      e = e >> 1;
    end
    total = 0;
    for (int i = 0; i < w; i++)
      for (int j = 0; j < w; j++) total = (total + pow_m[i][j]) % P;
    cnt = 30'((total * 2) % P);
  endtask

  task automatic report(input string msg);
    $display("zcmp_checker: %0t: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
  end

  assign pending = count_queue.size();

  always @(posedge clk) begin
    logic [29:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        zigzag_count(s_tdata[29:0], s_tdata[36:30], want);
        count_queue.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (count_queue.size() == 0) begin
          report($sformatf("unexpected result count=%0d", m_tdata[29:0]));
        end else begin
          want = count_queue.pop_front();
          if (m_tdata[29:0] !== want)
            report($sformatf("count got %0d want %0d", m_tdata[29:0], want));
        end
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the zig-zag count block: directed corner requests, then random
// requests kept mostly to small widths so each matrix power stays short, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import zcmp_pkg::*;

  localparam int N_RANDOM = 85;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // array_length[29:0], range_width[36:30], zero
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // count[29:0], zero

  int errors;
  int pending;
  int results_seen;
  int sent;
  bit stall_on;
  int stall_left;

  zigzag_count_matrix_power DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  zcmp_checker CHK (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 3);
  endfunction

  // result-side backpressure, switched off for stretches
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (!stall_on) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      stall_left <= gap_len();
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic [29:0] len, input logic [6:0] rw, input bit gaps);
    int g;
    s_tvalid <= 1'b1;
    s_tdata <= {3'b0, rw, len};
    do @(posedge clk); while (!s_tready);
    sent++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    logic [29:0] len;
    logic [6:0] rw;
    int pick;
    bit gaps;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    stall_on = 1'b0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners: zero length, zero width, width one, saturated widths, long lengths
    send_request(30'd0, 7'd3, 1'b0);
    send_request(30'd1, 7'd1, 1'b0);
    send_request(30'd2, 7'd1, 1'b0);
    send_request(30'h3FFFFFFF, 7'd1, 1'b0);
    send_request(30'h3FFFFFFF, 7'd2, 1'b1);
    send_request(30'd0, 7'd0, 1'b1);
    send_request(30'd5, 7'd0, 1'b0);
    send_request(30'h3FFFFFFF, 7'd0, 1'b0);
    send_request(30'd1, 7'd64, 1'b1);
    send_request(30'd0, 7'd127, 1'b0);
    send_request(30'd1, 7'd65, 1'b1);
    send_request(30'd2, 7'd2, 1'b0);
    send_request(30'd3, 7'd3, 1'b1);
    send_request(30'd10, 7'd4, 1'b0);
    send_request(30'h2AAAAAAA, 7'd3, 1'b1);
    send_request(30'd17, 7'd5, 1'b0);
    send_request(30'h15555555, 7'd2, 1'b1);

    stall_on = 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        rw = 7'($urandom_range(0, 2));
        len = 30'($urandom());
      end else if (pick < 9) begin
        rw = 7'($urandom_range(3, 5));
        len = 30'($urandom_range(0, 31));
      end else begin
        rw = 7'($urandom_range(64, 127));
        len = 30'($urandom_range(0, 1));
      end
      if (n % 25 == 0) stall_on = ~stall_on;
      gaps = (n % 25) < 18;
      send_request(len, rw, gaps);
    end
    s_tvalid <= 1'b0;
    stall_on = 1'b1;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("tb_top: %0d requests, %0d counts returned", sent, results_seen);
    $display("tb_top: widths 0..127 with saturation, lengths 0..2^30-1");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_top: timeout");
    $display("tb_top: errors");
    $finish;
  end

endmodule
